[hw/rtl/lcspe_pkg.sv]
package lcspe_pkg;

  localparam int NUM_TYPES_DEF = 16;

  localparam int OP_W    = 2;
  localparam int TYPE_W  = 4;
  localparam int SEL_W   = 2;
  localparam int COEF_W  = 24;
  localparam int ENERGY_W = 32;

  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam logic [SEL_W-1:0] SEL_EPSILON = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SIGMA   = 2'd1;
  localparam logic [SEL_W-1:0] SEL_CUTOFF  = 2'd2;

  // ratio divider: quotient bits, steps per stage
  localparam int DIV_BITS   = 36;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  // widths of the power chain below the huge limit, all with 32 fraction bits (U is Q3.32)
  localparam int U_W    = 35;
  localparam int U2_W   = 38;
  localparam int U4_W   = 44;
  localparam int X6_W   = 50;
  localparam int X6OK_W = 47;
  localparam int SQ_W   = 62;
  localparam int TERM_W = 64;
  localparam int MAG_W  = 63;
  localparam int E_W    = 57;

  localparam int MUL_LAT  = 2;
  localparam int TERM_LAT = DIV_STAGES + 4 * MUL_LAT + 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 32'h7FFF_FFFF;
  localparam logic [ENERGY_W-1:0] ENERGY_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_MAX,
    KIND_CALC
  } kind_e;

endpackage

[hw/rtl/lj_cut_shifted_pair_energy.sv]
// channel  valid    stall    payload
// in       valid_i  stall_o  opcode_i type_a_i type_b_i distance_i coeff_select_i coeff_value_i
// out      valid_o  stall_i  energy_o saturated_o read_value_o
//
// One transaction per cycle whenever stall_o is low.
// The latency is set by the ratio divider (two quotient bits per stage) and the
// chain of five split multipliers. After reset the coefficient memories are
// swept to zero, one entry a cycle, with stall_o high until the last entry is cleared.
// A stalled output holds the whole pipeline in place; nothing is lost or repeated.
module lj_cut_shifted_pair_energy #(
  parameter int NUM_TYPES = lcspe_pkg::NUM_TYPES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic [lcspe_pkg::OP_W-1:0]            opcode_i,
  input  logic [lcspe_pkg::TYPE_W-1:0]          type_a_i,
  input  logic [lcspe_pkg::TYPE_W-1:0]          type_b_i,
  input  logic [lcspe_pkg::COEF_W-1:0]          distance_i,
  input  logic [lcspe_pkg::SEL_W-1:0]           coeff_select_i,
  input  logic [lcspe_pkg::COEF_W-1:0]          coeff_value_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic signed [lcspe_pkg::ENERGY_W-1:0] energy_o,
  output logic                                  saturated_o,
  output logic [lcspe_pkg::COEF_W-1:0]          read_value_o
);
  import lcspe_pkg::*;

  localparam int PAIR_COUNT = NUM_TYPES * NUM_TYPES;
  localparam int ADDR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  typedef struct packed {
    logic              calc;
    logic              beyond;
    logic              zero;
    logic [COEF_W-1:0] eps;
    logic [COEF_W-1:0] rdval;
  } pre_t;

  typedef struct packed {
    kind_e             kind;
    logic              neg;
    logic [COEF_W-1:0] rdval;
  } post_t;

  logic [COEF_W-1:0] eps_mem [PAIR_COUNT];
  logic [COEF_W-1:0] sig_mem [PAIR_COUNT];
  logic [COEF_W-1:0] cut_mem [PAIR_COUNT];

  logic              en;
  logic              acc;
  logic              tv_in;
  logic [TYPE_W-1:0] lo_t;
  logic [TYPE_W-1:0] hi_t;
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] addr;

  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic              v1_q;
  logic [OP_W-1:0]   op1_q;
  logic              tv1_q;
  logic [COEF_W-1:0] r1_q;
  logic [SEL_W-1:0]  sel1_q;
  logic [COEF_W-1:0] eps_rd_q;
  logic [COEF_W-1:0] sig_rd_q;
  logic [COEF_W-1:0] cut_rd_q;
  pre_t              pre_d;

  logic              pv_q  [TERM_LAT];
  pre_t              pre_q [TERM_LAT];
  pre_t              pre_o;

  logic signed [TERM_W-1:0] term_a;
  logic signed [TERM_W-1:0] term_b;
  logic              huge_a;
  logic              huge_b;

  logic signed [TERM_W-1:0] diff;
  logic [TERM_W-1:0] mag;
  post_t             dst_d;
  logic              dv_q;
  post_t             dst_q;
  logic [MAG_W-1:0]  mag_q;
  logic [COEF_W-1:0] eps_d_q;

  logic              qv_q  [MUL_LAT];
  post_t             pst_q [MUL_LAT];
  post_t             pst;
  logic [E_W-1:0]    e_prod;

  logic [ENERGY_W-1:0] energy_d;
  logic                sat_d;
  logic                out_v_q;
  logic [ENERGY_W-1:0] energy_q;
  logic                sat_q;
  logic [COEF_W-1:0]   rd_q;

  assign en      = !(out_v_q && stall_i);
  assign stall_o = !en || clr_q;
  assign acc     = valid_i && !stall_o;

  assign tv_in     = (32'(type_a_i) < NUM_TYPES) && (32'(type_b_i) < NUM_TYPES);
  assign lo_t      = (type_a_i < type_b_i) ? type_a_i : type_b_i;
  assign hi_t      = (type_a_i < type_b_i) ? type_b_i : type_a_i;
  assign addr_full = 32'(lo_t) * NUM_TYPES + 32'(hi_t);
  assign addr      = tv_in ? addr_full[ADDR_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == ADDR_W'(PAIR_COUNT - 1)) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      eps_mem[clr_cnt_q] <= '0;
      sig_mem[clr_cnt_q] <= '0;
      cut_mem[clr_cnt_q] <= '0;
    end else if (acc && opcode_i == OP_WRITE && tv_in) begin
      case (coeff_select_i)
        SEL_EPSILON: eps_mem[addr] <= coeff_value_i;
        SEL_SIGMA:   sig_mem[addr] <= coeff_value_i;
        SEL_CUTOFF:  cut_mem[addr] <= coeff_value_i;
        default: ;
      endcase
    end
    if (en) begin
      eps_rd_q <= eps_mem[addr];
      sig_rd_q <= sig_mem[addr];
      cut_rd_q <= cut_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= opcode_i;
      tv1_q  <= tv_in;
      r1_q   <= distance_i;
      sel1_q <= coeff_select_i;
    end
  end

  always_comb begin
    pre_d.calc   = (op1_q == OP_COMPUTE) && tv1_q;
    pre_d.beyond = r1_q >= cut_rd_q;
    pre_d.zero   = r1_q == '0;
    pre_d.eps    = eps_rd_q;
    pre_d.rdval  = '0;
    if (op1_q == OP_READ && tv1_q) begin
      case (sel1_q)
        SEL_EPSILON: pre_d.rdval = eps_rd_q;
        SEL_SIGMA:   pre_d.rdval = sig_rd_q;
        SEL_CUTOFF:  pre_d.rdval = cut_rd_q;
        default:     pre_d.rdval = '0;
      endcase
    end
  end

  lcspe_term u_term_r (
    .clk_i, .en_i(en), .sigma_i(sig_rd_q), .dist_i(r1_q),
    .term_o(term_a), .huge_o(huge_a)
  );

  lcspe_term u_term_rc (
    .clk_i, .en_i(en), .sigma_i(sig_rd_q), .dist_i(cut_rd_q),
    .term_o(term_b), .huge_o(huge_b)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q[0] <= pre_d;
      for (int i = 1; i < TERM_LAT; i++) begin
        pre_q[i] <= pre_q[i-1];
      end
    end
  end

  assign pre_o = pre_q[TERM_LAT-1];
  assign diff  = term_a - term_b;
  assign mag   = diff[TERM_W-1] ? TERM_W'(-diff) : TERM_W'(diff);

  always_comb begin
    dst_d.neg   = diff[TERM_W-1];
    dst_d.rdval = pre_o.rdval;
    if (!pre_o.calc || pre_o.beyond) begin
      dst_d.kind = KIND_ZERO;
    end else if (pre_o.zero) begin
      dst_d.kind = KIND_MAX;
    end else if (pre_o.eps == '0) begin
      dst_d.kind = KIND_ZERO;
    end else if (huge_a || huge_b) begin
      dst_d.kind = KIND_MAX;
    end else begin
      dst_d.kind = KIND_CALC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dst_q   <= dst_d;
      mag_q   <= mag[MAG_W-1:0];
      eps_d_q <= pre_o.eps;
      pst_q[0] <= dst_q;
      for (int i = 1; i < MUL_LAT; i++) begin
        pst_q[i] <= pst_q[i-1];
      end
    end
  end

  lcspe_mul #(.AW(MAG_W), .BW(COEF_W), .SH(30), .OW(E_W)) u_mul_e (
    .clk_i, .en_i(en), .a_i(mag_q), .b_i(eps_d_q), .p_o(e_prod)
  );

  assign pst = pst_q[MUL_LAT-1];

  always_comb begin
    energy_d = '0;
    sat_d    = 1'b0;
    case (pst.kind)
      KIND_MAX: begin
        energy_d = ENERGY_MAX;
        sat_d    = 1'b1;
      end
      KIND_CALC: begin
        if (!pst.neg) begin
          if (e_prod > E_W'(ENERGY_MAX)) begin
            energy_d = ENERGY_MAX;
            sat_d    = 1'b1;
          end else begin
            energy_d = e_prod[ENERGY_W-1:0];
          end
        end else begin
          if (e_prod > E_W'(ENERGY_MIN)) begin
            energy_d = ENERGY_MIN;
            sat_d    = 1'b1;
          end else begin
            energy_d = -e_prod[ENERGY_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      dv_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < TERM_LAT; i++) begin
        pv_q[i] <= 1'b0;
      end
      for (int i = 0; i < MUL_LAT; i++) begin
        qv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= acc;
      pv_q[0] <= v1_q;
      for (int i = 1; i < TERM_LAT; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
      dv_q    <= pv_q[TERM_LAT-1];
      qv_q[0] <= dv_q;
      for (int i = 1; i < MUL_LAT; i++) begin
        qv_q[i] <= qv_q[i-1];
      end
      out_v_q <= qv_q[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= energy_d;
      sat_q    <= sat_d;
      rd_q     <= pst.rdval;
    end
  end

  assign valid_o      = out_v_q;
  assign energy_o     = energy_q;
  assign saturated_o  = sat_q;
  assign read_value_o = rd_q;

endmodule

[hw/rtl/lcspe_mul.sv]
module lcspe_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 32,
  parameter int OW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [OW-1:0] p_o
);
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll_q;
  logic [AL+BH-1:0] plh_q;
  logic [AH+BL-1:0] phl_q;
  logic [AH+BH-1:0] phh_q;
  logic [PW-1:0]    sum_d;
  logic [OW-1:0]    p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= a_i[AL-1:0] * b_i[BL-1:0];
      plh_q <= a_i[AL-1:0] * b_i[BW-1:BL];
      phl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
      phh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
      p_q   <= sum_d[SH +: OW];
    end
  end

  assign sum_d = (PW'(phh_q) << (AL + BL)) + (PW'(phl_q) << AL)
               + (PW'(plh_q) << BL) + PW'(pll_q);
  assign p_o = p_q;

endmodule

[hw/rtl/lcspe_term.sv]
module lcspe_term (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [lcspe_pkg::COEF_W-1:0]        sigma_i,
  input  logic [lcspe_pkg::COEF_W-1:0]        dist_i,
  output logic signed [lcspe_pkg::TERM_W-1:0] term_o,
  output logic                                huge_o
);
  import lcspe_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0]   rem;
    logic [DIV_BITS-1:0] qd;
  } div_t;

  function automatic div_t div_step(div_t x, logic [COEF_W-1:0] d);
    div_t          y;
    logic [COEF_W:0] t;
    logic [COEF_W:0] diff;
    logic          ge;
    y = x;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t    = {y.rem, y.qd[DIV_BITS-1]};
      ge   = t >= {1'b0, d};
      diff = t - {1'b0, d};
      y.rem = ge ? diff[COEF_W-1:0] : t[COEF_W-1:0];
      y.qd  = {y.qd[DIV_BITS-2:0], ge};
    end
    return y;
  endfunction

  div_t              div_q [DIV_STAGES];
  logic [COEF_W-1:0] dv_q  [DIV_STAGES];
  logic              hu_q  [DIV_STAGES];
  div_t              div_in [DIV_STAGES];
  logic [COEF_W-1:0] dv_in  [DIV_STAGES];
  logic              hu_in  [DIV_STAGES];

  logic [U2_W-1:0]   u2;
  logic [U4_W-1:0]   u4;
  logic [X6_W-1:0]   x6;
  logic [SQ_W-1:0]   sq;
  logic [U2_W-1:0]   u2_dly_q [MUL_LAT];
  logic              hga_q    [MUL_LAT];
  logic              hgb_q    [MUL_LAT];
  logic              hgc_q    [MUL_LAT];
  logic              hgd_q    [MUL_LAT];
  logic [X6_W-1:0]   x6_dly_q [MUL_LAT];
  logic              hx;
  logic signed [TERM_W-1:0] term_q;
  logic              huge_q;

  always_comb begin
    div_in[0] = '{rem: {4'b0, sigma_i[COEF_W-1:4]}, qd: {sigma_i[3:0], 32'b0}};
    dv_in[0]  = dist_i;
    hu_in[0]  = {3'b0, sigma_i} >= {dist_i, 3'b0};
    for (int k = 1; k < DIV_STAGES; k++) begin
      div_in[k] = div_q[k-1];
      dv_in[k]  = dv_q[k-1];
      hu_in[k]  = hu_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_q[k] <= div_step(div_in[k], dv_in[k]);
        dv_q[k]  <= dv_in[k];
        hu_q[k]  <= hu_in[k];
      end
    end
  end

  lcspe_mul #(.AW(U_W), .BW(U_W), .SH(32), .OW(U2_W)) u_mul_u2 (
    .clk_i, .en_i,
    .a_i (div_q[DIV_STAGES-1].qd[U_W-1:0]),
    .b_i (div_q[DIV_STAGES-1].qd[U_W-1:0]),
    .p_o (u2)
  );

  lcspe_mul #(.AW(U2_W), .BW(U2_W), .SH(32), .OW(U4_W)) u_mul_u4 (
    .clk_i, .en_i, .a_i(u2), .b_i(u2), .p_o(u4)
  );

  lcspe_mul #(.AW(U4_W), .BW(U2_W), .SH(32), .OW(X6_W)) u_mul_x6 (
    .clk_i, .en_i, .a_i(u4), .b_i(u2_dly_q[MUL_LAT-1]), .p_o(x6)
  );

  lcspe_mul #(.AW(X6OK_W), .BW(X6OK_W), .SH(32), .OW(SQ_W)) u_mul_sq (
    .clk_i, .en_i, .a_i(x6[X6OK_W-1:0]), .b_i(x6[X6OK_W-1:0]), .p_o(sq)
  );

  assign hx = hgc_q[MUL_LAT-1] | (x6[X6_W-1:X6OK_W] != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hga_q[0]    <= hu_q[DIV_STAGES-1];
      hgb_q[0]    <= hga_q[MUL_LAT-1];
      hgc_q[0]    <= hgb_q[MUL_LAT-1];
      hgd_q[0]    <= hx;
      u2_dly_q[0] <= u2;
      x6_dly_q[0] <= x6;
      for (int i = 1; i < MUL_LAT; i++) begin
        hga_q[i]    <= hga_q[i-1];
        hgb_q[i]    <= hgb_q[i-1];
        hgc_q[i]    <= hgc_q[i-1];
        hgd_q[i]    <= hgd_q[i-1];
        u2_dly_q[i] <= u2_dly_q[i-1];
        x6_dly_q[i] <= x6_dly_q[i-1];
      end
      term_q <= signed'({2'b0, sq}) - signed'({14'b0, x6_dly_q[MUL_LAT-1]});
      huge_q <= hgd_q[MUL_LAT-1];
    end
  end

  assign term_o = term_q;
  assign huge_o = huge_q;

endmodule

[hw/rtl/lcspe_check.sv]
module lcspe_check (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  valid_i,
  input logic                                  stall_o,
  input logic                                  valid_o,
  input logic                                  stall_i,
  input logic signed [lcspe_pkg::ENERGY_W-1:0] energy_o,
  input logic                                  saturated_o,
  input logic [lcspe_pkg::COEF_W-1:0]          read_value_o
);
  import lcspe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(energy_o) && $stable(saturated_o)
      && $stable(read_value_o))
    else $error("stalled result changed");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> energy_o == ENERGY_MAX || energy_o == ENERGY_MIN)
    else $error("saturated result not at a limit");

  a_read_no_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && read_value_o != '0 |-> energy_o == '0 && !saturated_o)
    else $error("read result carries energy");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> stall_o && !valid_o)
    else $error("block open straight after reset");

endmodule

bind lj_cut_shifted_pair_energy lcspe_check u_lcspe_check (.*);
